FILE: hw/rtl/mkdeb_pkg.sv
// Shared types and constants for the multi-key debounce and event latch.
`timescale 1ns / 1ps

package mkdeb_pkg;

  // Width of a settle counter and of the reload count registers.
  localparam int CNT_W = 8;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef logic [CNT_W-1:0] cnt_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_TICKS   = 1'b0,
    CFG_RELEASE_TICKS = 1'b1
  } cfg_idx_t;

  // Input item kinds.
  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  // Reset values of the reload count registers.
  localparam cnt_t PRESS_RESET   = 8'd2;
  localparam cnt_t RELEASE_RESET = 8'd20;

endpackage

FILE: hw/rtl/multi_key_debounce_event_latch_core.sv
// Top level of the multi-key debounce and pending press event latch.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_stall, in_kind, in_raw_keys) takes one item
// per transfer. A tick item samples the raw key levels and updates every key's
// debounce lane in parallel; it produces no result. A read item produces one
// result on the output channel (out_valid, out_stall, out_event_key): the
// lowest pending pressed key, whose pending bit is cleared, or NUM_KEYS when
// no event is pending.
// A read result is loaded into the output register in the cycle after the input
// transfer. One item per cycle is taken while in_stall is low, set by the single
// pass through the lane logic and the priority encoder into the output register.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes the press and
// release reload counts; a new count takes effect at a counter's next reload.
// Reset (rst_n low, synchronous) releases all keys, loads every counter with
// the press reset count, clears pending events and empties the output.
// While the receiver stalls a held result, in_stall is raised; once the result
// is taken, a new item may transfer in the same cycle.

module multi_key_debounce_event_latch_core #(
  parameter int NUM_KEYS = 9,
  localparam int KEY_W   = $clog2(NUM_KEYS + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic [NUM_KEYS-1:0]                in_raw_keys,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [KEY_W-1:0]                   out_event_key,
  input  logic                               cfg_we,
  input  logic [mkdeb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mkdeb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  mkdeb_pkg::cnt_t     press_ticks_r;
  mkdeb_pkg::cnt_t     release_ticks_r;
  logic                out_valid_r;
  logic [KEY_W-1:0]    out_event_key_r;
  logic                in_xfer;
  logic                tick_en;
  logic                read_en;
  logic [NUM_KEYS-1:0] press_set;
  logic [KEY_W-1:0]    event_key;

  // Input transfer decode.
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign tick_en  = in_xfer & (mkdeb_pkg::kind_t'(in_kind) == mkdeb_pkg::KIND_TICK);
  assign read_en  = in_xfer & (mkdeb_pkg::kind_t'(in_kind) == mkdeb_pkg::KIND_READ);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r   <= mkdeb_pkg::PRESS_RESET;
      release_ticks_r <= mkdeb_pkg::RELEASE_RESET;
    end else if (cfg_we) begin
      case (mkdeb_pkg::cfg_idx_t'(cfg_index))
        mkdeb_pkg::CFG_PRESS_TICKS:   press_ticks_r   <= mkdeb_pkg::cnt_t'(cfg_wdata);
        mkdeb_pkg::CFG_RELEASE_TICKS: release_ticks_r <= mkdeb_pkg::cnt_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  mkdeb_key_bank #(
    .NUM_KEYS (NUM_KEYS)
  ) u_key_bank (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_en       (tick_en),
    .raw_keys      (in_raw_keys),
    .press_ticks   (press_ticks_r),
    .release_ticks (release_ticks_r),
    .press_set     (press_set)
  );

  mkdeb_event_latch #(
    .NUM_KEYS (NUM_KEYS)
  ) u_event_latch (
    .clk       (clk),
    .rst_n     (rst_n),
    .press_set (press_set),
    .read_en   (read_en),
    .event_key (event_key)
  );

  // Output register: loaded on a read, emptied once the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (read_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_en) begin
      out_event_key_r <= event_key;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_key = out_event_key_r;

  // A read transfer always leaves a result in the output register.
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    read_en |=> out_valid_r)
    else $error("read transfer did not produce a result");

  // A tick never creates a result; the register empties unless one is held.
  a_tick_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_en && !in_stall) |=> !out_valid_r)
    else $error("tick transfer left a result in the output register");

  // Reported keys are in range: a key number or the no-event code.
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_event_key_r <= KEY_W'(NUM_KEYS)))
    else $error("event key out of range");

  // The input side stalls only while a result is held in the output register.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with an empty output register");

endmodule

FILE: hw/rtl/mkdeb_key_bank.sv
// Per-key debounce lanes: one debounced level and one settle counter per key.
`timescale 1ns / 1ps

module mkdeb_key_bank #(
  parameter int NUM_KEYS = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick_en,
  input  logic [NUM_KEYS-1:0] raw_keys,
  input  mkdeb_pkg::cnt_t     press_ticks,
  input  mkdeb_pkg::cnt_t     release_ticks,
  output logic [NUM_KEYS-1:0] press_set
);

  genvar k;
  generate
    for (k = 0; k < NUM_KEYS; k++) begin : g_lane
      logic            lvl_r;
      logic            lvl_nxt;
      mkdeb_pkg::cnt_t cnt_r;
      mkdeb_pkg::cnt_t cnt_nxt;
      mkdeb_pkg::cnt_t cnt_dec;
      logic            now;

      // A matching level reloads; a differing one counts down and settles at zero.
      always_comb begin
        now          = raw_keys[k];
        cnt_dec      = cnt_r - mkdeb_pkg::cnt_t'(1);
        lvl_nxt      = lvl_r;
        cnt_nxt      = cnt_r;
        press_set[k] = 1'b0;
        if (tick_en) begin
          if (now == lvl_r) begin
            cnt_nxt = now ? release_ticks : press_ticks;
          end else if (cnt_dec == '0) begin
            lvl_nxt      = now;
            cnt_nxt      = now ? release_ticks : press_ticks;
            press_set[k] = now;
          end else begin
            cnt_nxt = cnt_dec;
          end
        end
      end

      // Lane state.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          lvl_r <= 1'b0;
          cnt_r <= mkdeb_pkg::PRESS_RESET;
        end else begin
          lvl_r <= lvl_nxt;
          cnt_r <= cnt_nxt;
        end
      end
    end
  endgenerate

endmodule

FILE: hw/rtl/mkdeb_event_latch.sv
// Pending press event latch with a lowest-key-first priority encoder.
`timescale 1ns / 1ps

module mkdeb_event_latch #(
  parameter int NUM_KEYS = 9,
  localparam int KEY_W   = $clog2(NUM_KEYS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [NUM_KEYS-1:0] press_set,
  input  logic                read_en,
  output logic [KEY_W-1:0]    event_key
);

  logic [NUM_KEYS-1:0] pending_r;
  logic [NUM_KEYS-1:0] pending_nxt;
  logic [NUM_KEYS-1:0] lowest;

  // Isolate the lowest pending bit for clearing on a read.
  assign lowest = pending_r & (~pending_r + NUM_KEYS'(1));

  // Encode the lowest pending key, or the no-event code when none is pending.
  always_comb begin
    event_key = KEY_W'(NUM_KEYS);
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (pending_r[i]) begin
        event_key = KEY_W'(i);
      end
    end
  end

  // Set on accepted presses, clear the reported bit on a read.
  always_comb begin
    pending_nxt = pending_r | press_set;
    if (read_en) begin
      pending_nxt = pending_r & ~lowest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the multi-key debounce and pending event latch.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_KEYS    = 9;
  localparam int KEY_W       = 4;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLDOFF_LEN = 150;

  // Kinds of row in the directed stimulus table.
  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_READ,
    ROW_CFG
  } row_op_t;

  // Patterns the result receiver cycles through.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  typedef struct {
    row_op_t              op;
    logic [NUM_KEYS-1:0]  raw;
    mkdeb_pkg::cfg_idx_t  idx;
    mkdeb_pkg::cnt_t      value;
    bit                   typed;
    logic [KEY_W-1:0]     key;
  } dir_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             in_kind = mkdeb_pkg::KIND_TICK;
  logic [NUM_KEYS-1:0]              in_raw_keys = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [KEY_W-1:0]                 out_event_key;
  logic                             cfg_we = 1'b0;
  logic [mkdeb_pkg::CFG_IDX_W-1:0]  cfg_index = mkdeb_pkg::CFG_PRESS_TICKS;
  logic [mkdeb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow of the block: debounced levels, settle counters, pending presses.
  mkdeb_pkg::cnt_t     press_reload;
  mkdeb_pkg::cnt_t     release_reload;
  logic [NUM_KEYS-1:0] level_model;
  logic [NUM_KEYS-1:0] pending_model;
  mkdeb_pkg::cnt_t     settle_model [NUM_KEYS];

  logic [KEY_W-1:0] event_key_q [$];
  logic [KEY_W-1:0] wanted_key;
  int               error_count = 0;
  int               cycle_count = 0;

  // Receiver pattern and long hold-off bookkeeping.
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          holdoff_left = 0;
  int          holdoff_req = 0;
  int          holdoff_ack = 0;

  // Directed rows: typed results only where they follow at a glance.
  dir_row_t directed_rows [24] = '{
    '{ROW_READ, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b1, 4'd9},
    '{ROW_TICK, 9'h1FF, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_TICK, 9'h1FF, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_READ, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b1, 4'd0},
    '{ROW_READ, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b1, 4'd1},
    '{ROW_CFG,  9'h000, mkdeb_pkg::CFG_RELEASE_TICKS, 8'd1, 1'b0, 4'd0},
    '{ROW_TICK, 9'h1FF, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_TICK, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_TICK, 9'h155, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_TICK, 9'h155, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_READ, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_READ, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_CFG,  9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_TICK, 9'h0AA, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_TICK, 9'h0AA, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_TICK, 9'h1FF, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_READ, 9'h1FF, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_READ, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_READ, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_READ, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_READ, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_READ, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_READ, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0},
    '{ROW_READ, 9'h000, mkdeb_pkg::CFG_PRESS_TICKS,   8'd0, 1'b0, 4'd0}
  };

  multi_key_debounce_event_latch_core #(
    .NUM_KEYS(NUM_KEYS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_raw_keys  (in_raw_keys),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_event_key(out_event_key),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic mkdeb_pkg::cnt_t reload_count(logic lvl);
    return lvl ? release_reload : press_reload;
  endfunction

  // One sampling tick applied to every key lane of the shadow state.
  function automatic void debounce_tick(logic [NUM_KEYS-1:0] raw);
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (raw[k] == level_model[k]) begin
        settle_model[k] = reload_count(raw[k]);
      end else begin
        settle_model[k] = settle_model[k] - 1'b1;
        if (settle_model[k] == '0) begin
          level_model[k] = raw[k];
          if (raw[k])
            pending_model[k] = 1'b1;
          settle_model[k] = reload_count(raw[k]);
        end
      end
    end
  endfunction

  // Lowest pending press, cleared as it is taken; NUM_KEYS when none.
  function automatic logic [KEY_W-1:0] take_lowest_event();
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (pending_model[k]) begin
        pending_model[k] = 1'b0;
        return KEY_W'(k);
      end
    end
    return KEY_W'(NUM_KEYS);
  endfunction

  // Output side: every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (event_key_q.size() == 0) begin
        report_mismatch($sformatf("event key %0d with nothing expected", out_event_key));
      end else begin
        wanted_key = event_key_q.pop_front();
        if (out_event_key !== wanted_key)
          report_mismatch($sformatf("event key %0d, expected %0d", out_event_key,
                                    wanted_key));
      end
    end
  end

  // Receiver: random stall patterns, with a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_req != holdoff_ack) begin
      out_stall    <= 1'b1;
      holdoff_ack  <= holdoff_ack + 1;
      holdoff_left <= HOLDOFF_LEN;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(10, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 99) < 30);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 99) < 70);
        STALL_TOGGLE: out_stall <= ~out_stall;
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  // Offer one item and hold it until its transfer, then update the shadow.
  task automatic send_item(mkdeb_pkg::kind_t kind, logic [NUM_KEYS-1:0] raw, bit typed,
                           logic [KEY_W-1:0] typed_key);
    logic [KEY_W-1:0] predicted;
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_raw_keys <= raw;
    do @(posedge clk); while (in_stall);
    if (kind == mkdeb_pkg::KIND_TICK) begin
      debounce_tick(raw);
    end else begin
      predicted = take_lowest_event();
      event_key_q.push_back(typed ? typed_key : predicted);
    end
  endtask

  // Sender idles until every expected result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (event_key_q.size() != 0);
  endtask

  // Register write with the block idle; the pause covers a tick still in flight.
  task automatic write_reg(mkdeb_pkg::cfg_idx_t idx, mkdeb_pkg::cnt_t value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mkdeb_pkg::CFG_PRESS_TICKS:   press_reload = value;
      mkdeb_pkg::CFG_RELEASE_TICKS: release_reload = value;
      default: ;
    endcase
  endtask

  // Random phase: keys held at a target pattern, half the time long enough
  // to settle, with contact bounce, reads mixed in, and bursty offering.
  task automatic run_phase(mkdeb_pkg::cnt_t press, mkdeb_pkg::cnt_t release_cnt,
                           int items, int read_pct, int noise_pct, bit with_holdoff);
    logic [NUM_KEYS-1:0] held;
    logic [NUM_KEYS-1:0] raw;
    mkdeb_pkg::kind_t    kind;
    int                  hold_left;
    int                  span;
    int                  burst_left;
    int                  gap;
    int                  sent;
    int                  bit_idx;
    write_reg(mkdeb_pkg::CFG_PRESS_TICKS, press);
    write_reg(mkdeb_pkg::CFG_RELEASE_TICKS, release_cnt);
    if (with_holdoff)
      holdoff_req <= holdoff_req + 1;
    span = (press == 0) ? 256 : int'(press);
    if (release_cnt == 0)
      span = 256;
    else if (int'(release_cnt) > span)
      span = int'(release_cnt);
    held      = level_model;
    hold_left = 0;
    sent      = 0;
    while (sent < items) begin
      burst_left = $urandom_range(1, 30);
      while (burst_left > 0 && sent < items) begin
        if ($urandom_range(0, 99) < read_pct) begin
          kind = mkdeb_pkg::KIND_READ;
          raw  = NUM_KEYS'($urandom);
        end else begin
          kind = mkdeb_pkg::KIND_TICK;
          if (hold_left == 0) begin
            if ($urandom_range(0, 9) == 0)
              held = NUM_KEYS'($urandom);
            else
              held ^= NUM_KEYS'($urandom & $urandom);
            hold_left = $urandom_range(0, 1) ? $urandom_range(1, span)
                                             : span + $urandom_range(1, 8);
          end
          hold_left--;
          raw = held;
          if ($urandom_range(0, 99) < noise_pct) begin
            bit_idx = $urandom_range(0, NUM_KEYS - 1);
            raw[bit_idx] = ~raw[bit_idx];
          end
        end
        send_item(kind, raw, 1'b0, '0);
        sent++;
        burst_left--;
      end
      // Gap between bursts; now and then wait for every result to come back.
      if ($urandom_range(0, 49) == 0) begin
        drain_results();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  // Stimulus and end of run.
  initial begin
    press_reload   = mkdeb_pkg::PRESS_RESET;
    release_reload = mkdeb_pkg::RELEASE_RESET;
    level_model    = '0;
    pending_model  = '0;
    for (int k = 0; k < NUM_KEYS; k++)
      settle_model[k] = mkdeb_pkg::PRESS_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the reset counts.
    foreach (directed_rows[i]) begin
      case (directed_rows[i].op)
        ROW_TICK: send_item(mkdeb_pkg::KIND_TICK, directed_rows[i].raw, 1'b0, '0);
        ROW_READ: send_item(mkdeb_pkg::KIND_READ, directed_rows[i].raw,
                            directed_rows[i].typed, directed_rows[i].key);
        ROW_CFG:  write_reg(directed_rows[i].idx, directed_rows[i].value);
        default: ;
      endcase
    end

    // Random part over several count settings, the extremes among them.
    run_phase(8'd1,   8'd1,   250, 25, 10, 1'b0);
    run_phase(8'd3,   8'd5,   300, 25, 15, 1'b1);
    run_phase(8'd255, 8'd1,   400, 15,  2, 1'b0);
    run_phase(8'd0,   8'd0,   700, 10,  0, 1'b0);
    run_phase(mkdeb_pkg::cnt_t'($urandom_range(1, 8)),
              mkdeb_pkg::cnt_t'($urandom_range(1, 8)), 200, 30, 10, 1'b1);

    while (event_key_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (event_key_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never came", event_key_q.size()));

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
